[hdl/sasr_pkg.sv]
`default_nettype none

package sasr_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W = 64;
   localparam int RCNT_W = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_SCAN = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_ORDER = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_MASK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTER_WIDTH = 1'd1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [RCNT_W-1:0] remaining_count;
      logic [DATA_W-1:0] entry;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic              remove;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

   function automatic logic [DATA_W-1:0] cut(input logic [DATA_W-1:0] v, input logic wide);
      cut = wide ? v : {32'd0, v[31:0]};
   endfunction

endpackage

`default_nettype wire

[hdl/sorted_address_scan_remove_top.sv]
// channel   ports                                  handshake
// request   start, busy, req_data                  taken when start and not busy
// response  rsp_valid, rsp_data                    one-cycle strobe, cannot be held off
// config    csr_valid, csr_ready, csr_index/data   written when valid and ready
//
// the table is a row of cells; a removal shifts all upper cells down together
// every table read goes through a two-stage registered mux
// a full or empty load, a read out of range or cmd 3 answer without a table read
// a scan is skipped, stops below the first entry or above the last, or searches by probes
// up to 11 probes over a full table
// synchronous reset clears control, count and mask; data regs and cells stay undefined
// busy stays high until the response strobe is issued; the receiver never stalls
`default_nettype none

module sorted_address_scan_remove_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire sasr_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   output sasr_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sasr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sasr_pkg::DATA_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WAIT = 3'b010,
      S_EVAL = 3'b100
   } state_type;

   typedef enum logic [4:0] {
      P_LOAD_CMP = 5'b00001,
      P_READ     = 5'b00010,
      P_CHK_LO   = 5'b00100,
      P_CHK_HI   = 5'b01000,
      P_PROBE    = 5'b10000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic wait_ff, wait_in;
   logic [sasr_pkg::DATA_W-1:0] word_ff, word_in;
   logic [sasr_pkg::CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [sasr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [sasr_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [sasr_pkg::DATA_W-1:0] mask_ff, mask_in;
   logic pw_ff, pw_in;
   sasr_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   sasr_pkg::cell_cmd_type cell_cmd;

   logic [sasr_pkg::DATA_W-1:0] cell_value [sasr_pkg::TABLE_DEPTH];
   logic [sasr_pkg::DATA_W-1:0] rd_data;

   genvar i;
   generate
      for (i = 0; i < sasr_pkg::TABLE_DEPTH; i++) begin : g_cell
         sasr_cell u_cell (
            .clock    (clock),
            .my_index (sasr_pkg::IDX_W'(i)),
            .cmd      (cell_cmd),
            .upper    (cell_value[(i < sasr_pkg::TABLE_DEPTH - 1) ? i + 1 : i]),
            .value    (cell_value[i])
         );
      end
   endgenerate

   sasr_read_tree u_read_tree (
      .clock    (clock),
      .cells    (cell_value),
      .rd_index (rd_idx_ff),
      .rd_data  (rd_data)
   );

   always_comb begin
      logic [sasr_pkg::DATA_W-1:0] w;
      logic [sasr_pkg::DATA_W-1:0] v;
      logic [sasr_pkg::CNT_W-1:0] nlo;
      logic [sasr_pkg::CNT_W-1:0] nhi;
      logic [sasr_pkg::CNT_W:0] sum;

      state_in = state_ff;
      phase_in = phase_ff;
      wait_in = wait_ff;
      word_in = word_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      count_in = count_ff;
      rd_idx_in = rd_idx_ff;
      mask_in = mask_ff;
      pw_in = pw_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      cell_cmd = '0;
      w = sasr_pkg::cut(req_data.value, pw_ff);
      v = sasr_pkg::cut(rd_data, pw_ff);
      nlo = lo_ff;
      nhi = hi_ff;
      sum = '0;

      if (csr_valid) begin
         unique case (csr_index)
            sasr_pkg::CSR_SCAN_MASK: mask_in = csr_data;
            sasr_pkg::CSR_POINTER_WIDTH: pw_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               word_in = w;
               rsp_in = '0;
               wait_in = 1'b0;
               unique case (req_data.cmd)
                  sasr_pkg::CMD_LOAD: begin
                     priority if (count_ff >= sasr_pkg::CNT_W'(sasr_pkg::TABLE_DEPTH)) begin
                        rsp_in.status = sasr_pkg::ST_FULL;
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == '0) begin
                        cell_cmd.load = 1'b1;
                        cell_cmd.pos = '0;
                        cell_cmd.data = w;
                        count_in = count_ff + 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_idx_in = sasr_pkg::IDX_W'(count_ff - 1'b1);
                        phase_in = P_LOAD_CMP;
                        state_in = S_WAIT;
                     end
                  end
                  sasr_pkg::CMD_SCAN: begin
                     if (count_ff == '0 || (w & mask_ff) != '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_idx_in = '0;
                        phase_in = P_CHK_LO;
                        state_in = S_WAIT;
                     end
                  end
                  sasr_pkg::CMD_READ: begin
                     if (req_data.value < sasr_pkg::DATA_W'(count_ff)) begin
                        rd_idx_in = req_data.value[sasr_pkg::IDX_W-1:0];
                        phase_in = P_READ;
                        state_in = S_WAIT;
                     end else begin
                        rsp_in.status = sasr_pkg::ST_RANGE;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_in.remaining_count = sasr_pkg::RCNT_W'(count_in);
            end
         end
         S_WAIT: begin
            wait_in = 1'b1;
            if (wait_ff) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            wait_in = 1'b0;
            state_in = S_WAIT;
            unique case (phase_ff)
               P_LOAD_CMP: begin
                  if (word_ff <= v) begin
                     rsp_in.status = sasr_pkg::ST_ORDER;
                  end else begin
                     cell_cmd.load = 1'b1;
                     cell_cmd.pos = sasr_pkg::IDX_W'(count_ff);
                     cell_cmd.data = word_ff;
                     count_in = count_ff + 1'b1;
                  end
                  rsp_valid_in = 1'b1;
               end
               P_READ: begin
                  rsp_in.entry = v;
                  rsp_valid_in = 1'b1;
               end
               P_CHK_LO: begin
                  if (word_ff < v) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     rd_idx_in = sasr_pkg::IDX_W'(count_ff - 1'b1);
                     phase_in = P_CHK_HI;
                  end
               end
               P_CHK_HI: begin
                  if (word_ff > v) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     lo_in = '0;
                     hi_in = count_ff;
                     mid_in = count_ff >> 1;
                     rd_idx_in = sasr_pkg::IDX_W'(count_ff >> 1);
                     phase_in = P_PROBE;
                  end
               end
               P_PROBE: begin
                  priority if (word_ff < v) begin
                     nhi = mid_ff;
                  end else if (word_ff > v) begin
                     nlo = mid_ff + 1'b1;
                  end else begin
                     cell_cmd.remove = 1'b1;
                     cell_cmd.pos = sasr_pkg::IDX_W'(mid_ff);
                     count_in = count_ff - 1'b1;
                     rsp_in.hit = 1'b1;
                     rsp_in.entry = word_ff;
                     rsp_valid_in = 1'b1;
                  end
                  if (!rsp_valid_in) begin
                     if (nlo < nhi) begin
                        sum = {1'b0, nlo} + {1'b0, nhi};
                        lo_in = nlo;
                        hi_in = nhi;
                        mid_in = sum[sasr_pkg::CNT_W:1];
                        rd_idx_in = sasr_pkg::IDX_W'(sum[sasr_pkg::CNT_W:1]);
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
            if (rsp_valid_in) begin
               state_in = S_IDLE;
            end
            rsp_in.remaining_count = sasr_pkg::RCNT_W'(count_in);
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= P_READ;
         wait_ff <= 1'b0;
         count_ff <= '0;
         mask_ff <= '0;
         pw_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wait_ff <= wait_in;
         count_ff <= count_in;
         mask_ff <= mask_in;
         pw_ff <= pw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff <= word_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

[hdl/sasr_cell.sv]
`default_nettype none

module sasr_cell (
   input  wire logic                         clock,
   input  wire logic [sasr_pkg::IDX_W-1:0]   my_index,
   input  wire sasr_pkg::cell_cmd_type       cmd,
   input  wire logic [sasr_pkg::DATA_W-1:0]  upper,
   output logic [sasr_pkg::DATA_W-1:0]       value
);

   logic [sasr_pkg::DATA_W-1:0] value_ff;
   logic [sasr_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      priority if (cmd.load && cmd.pos == my_index) begin
         value_in = cmd.data;
      end else if (cmd.remove && my_index >= cmd.pos) begin
         value_in = upper;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[hdl/sasr_read_tree.sv]
`default_nettype none

module sasr_read_tree (
   input  wire logic                         clock,
   input  wire logic [sasr_pkg::DATA_W-1:0]  cells [sasr_pkg::TABLE_DEPTH],
   input  wire logic [sasr_pkg::IDX_W-1:0]   rd_index,
   output logic [sasr_pkg::DATA_W-1:0]       rd_data
);

   localparam int LO_W = (sasr_pkg::IDX_W > 5) ? 5 : sasr_pkg::IDX_W;
   localparam int GROUP = 1 << LO_W;
   localparam int NUM_GROUPS = (sasr_pkg::TABLE_DEPTH + GROUP - 1) / GROUP;

   logic [sasr_pkg::DATA_W-1:0] group_ff [NUM_GROUPS];
   logic [sasr_pkg::DATA_W-1:0] group_in [NUM_GROUPS];
   logic [sasr_pkg::IDX_W-1:0]  sel_ff;
   logic [sasr_pkg::DATA_W-1:0] data_ff;
   logic [sasr_pkg::DATA_W-1:0] data_in;

   // first level: one entry per group by the low index bits
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if ((g * GROUP + k) < sasr_pkg::TABLE_DEPTH && int'(rd_index[LO_W-1:0]) == k) begin
               group_in[g] = cells[g * GROUP + k];
            end
         end
      end
   end

   // second level: pick the group by the high index bits
   always_comb begin
      data_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (int'(sel_ff >> LO_W) == g) begin
            data_in = group_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      sel_ff <= rd_index;
      data_ff <= data_in;
   end

   assign rd_data = data_ff;

endmodule

`default_nettype wire
